// ===== hdl/pkq_pkg.sv =====
// ============================================================================
// pkq_pkg: shared definitions for the positional key queue
// Command and status codes, field widths and default sizes.
// ============================================================================
`default_nettype none

package pkq_pkg;

    localparam int DEPTH_DEF    = 16;
    localparam int KEY_BITS_DEF = 16;

    localparam int CMD_BITS    = 3;
    localparam int KEY_IO_BITS = 16;
    localparam int POS_BITS    = 5;
    localparam int STATUS_BITS = 2;
    localparam int COUNT_BITS  = 5;

    localparam logic [CMD_BITS-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_SEARCH = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_INSERT = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_REMOVE = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_COUNT  = 3'd4;
    localparam logic [CMD_BITS-1:0] CMD_RD_FWD = 3'd5;
    localparam logic [CMD_BITS-1:0] CMD_RD_REV = 3'd6;

    localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_NOTFOUND = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY    = 2'd3;

endpackage

`default_nettype wire

// ===== hdl/pkq_ram.sv =====
// ============================================================================
// pkq_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module pkq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/positional_key_queue_unit.sv =====
// ============================================================================
// positional_key_queue_unit: ordered queue of signed keys
// Append, search, positional insert, remove-all, count and read-out commands
// over a key store walked one entry at a time by a small sequencer.
// ============================================================================
//
//  Channel   Handshake            Payload
//  --------  -------------------  ----------------------------------------
//  input     in_valid / in_stall  command, key, position
//  output    out_valid/out_stall  status, key_out, entry_count, last
//
//  Append, count and rejected commands go straight to the result beat.
//  Search and remove read and check each held entry in turn. Insert moves
//  each entry from the position on up one place, then writes the key.
//  Read-outs give one beat per entry. All walks go through the single read
//  and write port of the key store. Reset empties the queue at once. A
//  waiting output beat holds the sequencer only when it has a beat to give.
//
`default_nettype none

module positional_key_queue_unit
    import pkq_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic        [CMD_BITS-1:0]    command,
    input  wire logic signed [KEY_IO_BITS-1:0] key,
    input  wire logic        [POS_BITS-1:0]    position,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic             [STATUS_BITS-1:0] status,
    output logic signed      [KEY_IO_BITS-1:0] key_out,
    output logic             [COUNT_BITS-1:0]  entry_count,
    output logic                               last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = ((CW > POS_BITS) ? CW : POS_BITS) + 1;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SCAN_RD  = 4'd1;
    localparam logic [3:0] S_SCAN_CHK = 4'd2;
    localparam logic [3:0] S_SHIFT_RD = 4'd3;
    localparam logic [3:0] S_SHIFT_WR = 4'd4;
    localparam logic [3:0] S_PLACE    = 4'd5;
    localparam logic [3:0] S_EMIT     = 4'd6;
    localparam logic [3:0] S_RO_RD    = 4'd7;
    localparam logic [3:0] S_RO_OUT   = 4'd8;

    logic [3:0]                    state_reg, state_next;
    logic [CW-1:0]                 occ_reg, occ_next;
    logic [CW-1:0]                 idx_reg, idx_next;
    logic [CW-1:0]                 wr_idx_reg, wr_idx_next;
    logic                          hit_reg, hit_next;
    logic [CMD_BITS-1:0]           cmd_reg, cmd_next;
    logic signed [KEY_BITS-1:0]    key_reg, key_next;
    logic [POS_BITS-1:0]           pos_reg, pos_next;
    logic [STATUS_BITS-1:0]        res_reg, res_next;

    logic                          out_valid_reg, out_valid_next;
    logic [STATUS_BITS-1:0]        out_status_reg, out_status_next;
    logic signed [KEY_IO_BITS-1:0] out_key_reg, out_key_next;
    logic                          out_last_reg, out_last_next;
    logic [COUNT_BITS-1:0]         out_count_reg, out_count_next;

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [KEY_BITS-1:0]           ram_wdata;
    logic [AW-1:0]                 ram_raddr;
    logic signed [KEY_BITS-1:0]    ram_rdata;

    logic                          accept;
    logic                          out_free;
    logic                          full;
    logic signed [KEY_BITS-1:0]    key_in;
    logic [PW-1:0]                 occ_ext;
    logic [PW-1:0]                 pos_in_ext;
    logic [PW-1:0]                 pos_ext;
    logic [CW-1:0]                 idx_inc;
    logic [CW-1:0]                 idx_dec;
    logic [CW-1:0]                 wr_inc;
    logic [CW-1:0]                 rev_idx;
    logic [PW-1:0]                 place_addr;
    logic                          match;
    logic                          scan_done;
    logic                          ro_last;

    pkq_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_stall   = (state_reg != S_IDLE);
    assign accept     = in_valid && (state_reg == S_IDLE);
    assign out_free   = !out_valid_reg || !out_stall;
    assign full       = (occ_reg >= CW'(DEPTH));
    assign key_in     = KEY_BITS'(key);
    assign occ_ext    = PW'(occ_reg);
    assign pos_in_ext = PW'(position);
    assign pos_ext    = PW'(pos_reg);
    assign idx_inc    = idx_reg + CW'(1);
    assign idx_dec    = idx_reg - CW'(1);
    assign wr_inc     = wr_idx_reg + CW'(1);
    assign rev_idx    = occ_reg - CW'(1) - idx_reg;
    assign place_addr = pos_ext - PW'(1);
    assign match      = (ram_rdata == key_reg);
    assign scan_done  = (idx_inc == occ_reg);
    assign ro_last    = (idx_inc == occ_reg);

    always_comb
    begin
        ram_raddr = idx_reg[AW-1:0];
        if (state_reg == S_SHIFT_RD)
        begin
            ram_raddr = idx_dec[AW-1:0];
        end
        else if ((state_reg == S_RO_RD || state_reg == S_RO_OUT) &&
                 cmd_reg == CMD_RD_REV)
        begin
            ram_raddr = rev_idx[AW-1:0];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        occ_next        = occ_reg;
        idx_next        = idx_reg;
        wr_idx_next     = wr_idx_reg;
        hit_next        = hit_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        pos_next        = pos_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_key_next    = out_key_reg;
        out_last_next   = out_last_reg;
        out_count_next  = out_count_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg[AW-1:0];
        ram_wdata       = ram_rdata;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = command;
                    key_next    = key_in;
                    pos_next    = position;
                    idx_next    = '0;
                    wr_idx_next = '0;
                    hit_next    = 1'b0;
                    state_next  = S_EMIT;
                    res_next    = ST_OK;
                    unique case (command)
                        CMD_APPEND:
                        begin
                            if (full)
                            begin
                                res_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = occ_reg[AW-1:0];
                                ram_wdata = key_in;
                                occ_next  = occ_reg + CW'(1);
                            end
                        end
                        CMD_SEARCH, CMD_REMOVE:
                        begin
                            if (occ_reg == '0)
                            begin
                                res_next = ST_NOTFOUND;
                            end
                            else
                            begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        CMD_INSERT:
                        begin
                            if (full)
                            begin
                                res_next = ST_FULL;
                            end
                            else if (position == '0 || pos_in_ext > occ_ext + PW'(1))
                            begin
                                res_next = ST_NOTFOUND;
                            end
                            else
                            begin
                                idx_next = occ_reg;
                                if (occ_ext >= pos_in_ext)
                                begin
                                    state_next = S_SHIFT_RD;
                                end
                                else
                                begin
                                    state_next = S_PLACE;
                                end
                            end
                        end
                        CMD_COUNT:
                        begin
                            res_next = ST_OK;
                        end
                        CMD_RD_FWD, CMD_RD_REV:
                        begin
                            if (occ_reg == '0)
                            begin
                                res_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_RO_RD;
                            end
                        end
                        default:
                        begin
                            res_next = ST_NOTFOUND;
                        end
                    endcase
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (match)
                begin
                    hit_next = 1'b1;
                end
                else if (cmd_reg == CMD_REMOVE)
                begin
                    ram_we      = 1'b1;
                    ram_waddr   = wr_idx_reg[AW-1:0];
                    wr_idx_next = wr_inc;
                end
                idx_next = idx_inc;
                if (scan_done)
                begin
                    state_next = S_EMIT;
                    if (hit_reg || match)
                    begin
                        res_next = ST_OK;
                        if (cmd_reg == CMD_REMOVE)
                        begin
                            occ_next = match ? wr_idx_reg : wr_inc;
                        end
                    end
                    else
                    begin
                        res_next = ST_NOTFOUND;
                    end
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SHIFT_RD:
            begin
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                ram_we   = 1'b1;
                idx_next = idx_dec;
                if (PW'(idx_reg) > pos_ext)
                begin
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = place_addr[AW-1:0];
                ram_wdata  = key_reg;
                occ_next   = occ_reg + CW'(1);
                res_next   = ST_OK;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_reg;
                    out_key_next    = '0;
                    out_last_next   = 1'b1;
                    out_count_next  = COUNT_BITS'(occ_reg);
                    state_next      = S_IDLE;
                end
            end
            S_RO_RD:
            begin
                state_next = S_RO_OUT;
            end
            S_RO_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_key_next    = KEY_IO_BITS'(ram_rdata);
                    out_last_next   = ro_last;
                    out_count_next  = COUNT_BITS'(occ_reg);
                    idx_next        = idx_inc;
                    state_next      = ro_last ? S_IDLE : S_RO_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        wr_idx_reg     <= wr_idx_next;
        hit_reg        <= hit_next;
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        pos_reg        <= pos_next;
        res_reg        <= res_next;
        out_status_reg <= out_status_next;
        out_key_reg    <= out_key_next;
        out_last_reg   <= out_last_next;
        out_count_reg  <= out_count_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign key_out     = out_key_reg;
    assign entry_count = out_count_reg;
    assign last        = out_last_reg;

endmodule

`default_nettype wire

// ===== tb/tb_positional_key_queue_unit.sv =====
// ============================================================================
// tb_positional_key_queue_unit: self-checking bench for the key queue
// Drives append, search, insert, remove, count and read-out commands with
// random idling on both channels and checks every result beat against a
// behavioral copy of the queue kept inside the bench.
// ============================================================================
`default_nettype none

module tb_positional_key_queue_unit;
    import pkq_pkg::*;

    localparam int QUEUE_DEPTH = DEPTH_DEF;
    localparam logic [CMD_BITS-1:0] CMD_UNUSED = 3'd7;
    localparam int CHUNK_ITEMS = 22;
    localparam int END_CYCLES = 80;
    localparam int MAX_REPORTS = 20;

    typedef struct packed {
        logic [CMD_BITS-1:0]           cmd;
        logic signed [KEY_IO_BITS-1:0] k;
        logic [POS_BITS-1:0]           pos;
    } queue_cmd_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0]        status;
        logic signed [KEY_IO_BITS-1:0] key_out;
        logic [COUNT_BITS-1:0]         entry_count;
        logic                          last;
    } queue_beat_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [CMD_BITS-1:0]           command = CMD_COUNT;
    logic signed [KEY_IO_BITS-1:0] key = '0;
    logic [POS_BITS-1:0]           position = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [STATUS_BITS-1:0]        status;
    logic signed [KEY_IO_BITS-1:0] key_out;
    logic [COUNT_BITS-1:0]         entry_count;
    logic                          last;

    queue_cmd_t                    pending_cmds[$];
    queue_cmd_t                    next_cmd;
    queue_beat_t                   expected_beats[$];
    queue_beat_t                   oldest_beat;
    logic signed [KEY_IO_BITS-1:0] held_keys[$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    int error_count = 0;
    int commands_accepted = 0;
    int beats_checked = 0;
    int readout_beats = 0;
    int full_refusals = 0;
    int miss_refusals = 0;

    positional_key_queue_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .key         (key),
        .position    (position),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .key_out     (key_out),
        .entry_count (entry_count),
        .last        (last)
    );

    always #4 clk = ~clk;

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_REPORTS)
        begin
            $display("mismatch at %0t: %s", $time, what);
        end
    endtask

    task automatic predict_queue_command(input logic [CMD_BITS-1:0] cmd,
                                         input logic signed [KEY_IO_BITS-1:0] k,
                                         input logic [POS_BITS-1:0] pos);
        queue_beat_t                   beat;
        logic signed [KEY_IO_BITS-1:0] kept[$];
        bit                            hit;
        int                            held;
        beat = '{status: ST_OK, key_out: '0, entry_count: '0, last: 1'b1};
        hit = 1'b0;
        held = held_keys.size();
        case (cmd)
            CMD_APPEND:
            begin
                if (held >= QUEUE_DEPTH)
                    beat.status = ST_FULL;
                else
                    held_keys.push_back(k);
            end
            CMD_SEARCH:
            begin
                foreach (held_keys[i])
                    if (held_keys[i] == k)
                        hit = 1'b1;
                beat.status = hit ? ST_OK : ST_NOTFOUND;
            end
            CMD_INSERT:
            begin
                if (held >= QUEUE_DEPTH)
                    beat.status = ST_FULL;
                else if (pos == 0 || int'(pos) > held + 1)
                    beat.status = ST_NOTFOUND;
                else
                    held_keys.insert(int'(pos) - 1, k);
            end
            CMD_REMOVE:
            begin
                foreach (held_keys[i])
                begin
                    if (held_keys[i] == k)
                        hit = 1'b1;
                    else
                        kept.push_back(held_keys[i]);
                end
                if (hit)
                    held_keys = kept;
                beat.status = hit ? ST_OK : ST_NOTFOUND;
            end
            CMD_COUNT:
            begin
                beat.status = ST_OK;
            end
            CMD_RD_FWD, CMD_RD_REV:
            begin
                if (held == 0)
                begin
                    beat.status = ST_EMPTY;
                end
                else
                begin
                    for (int i = 0; i < held; i++)
                    begin
                        beat.status = ST_OK;
                        beat.key_out = (cmd == CMD_RD_FWD) ? held_keys[i]
                                                           : held_keys[held - 1 - i];
                        beat.entry_count = COUNT_BITS'(held);
                        beat.last = (i == held - 1);
                        expected_beats.push_back(beat);
                    end
                    readout_beats += held;
                    return;
                end
            end
            default:
            begin
                beat.status = ST_NOTFOUND;
            end
        endcase
        if (beat.status == ST_FULL)
            full_refusals++;
        if (beat.status == ST_NOTFOUND)
            miss_refusals++;
        beat.entry_count = COUNT_BITS'(held_keys.size());
        expected_beats.push_back(beat);
    endtask

    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            predict_queue_command(command, key, position);
            commands_accepted++;
        end
        if (!in_valid || !in_stall)
        begin
            if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                next_cmd = pending_cmds.pop_front();
                in_valid <= 1'b1;
                command <= next_cmd.cmd;
                key <= next_cmd.k;
                position <= next_cmd.pos;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_beats.size() == 0)
            begin
                report_mismatch($sformatf("beat with nothing expected, status %0d key %0d",
                                          status, key_out));
            end
            else
            begin
                oldest_beat = expected_beats.pop_front();
                if (status !== oldest_beat.status)
                    report_mismatch($sformatf("beat %0d status %0d, expected %0d",
                                              beats_checked, status, oldest_beat.status));
                if (key_out !== oldest_beat.key_out)
                    report_mismatch($sformatf("beat %0d key_out %0d, expected %0d",
                                              beats_checked, key_out, oldest_beat.key_out));
                if (entry_count !== oldest_beat.entry_count)
                    report_mismatch($sformatf("beat %0d entry_count %0d, expected %0d",
                                              beats_checked, entry_count,
                                              oldest_beat.entry_count));
                if (last !== oldest_beat.last)
                    report_mismatch($sformatf("beat %0d last %0b, expected %0b",
                                              beats_checked, last, oldest_beat.last));
                beats_checked++;
            end
        end
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    task automatic push_cmd(input logic [CMD_BITS-1:0] cmd,
                            input logic signed [KEY_IO_BITS-1:0] k,
                            input logic [POS_BITS-1:0] pos);
        pending_cmds.push_back('{cmd: cmd, k: k, pos: pos});
    endtask

    function automatic logic signed [KEY_IO_BITS-1:0] pick_key();
        case ($urandom_range(0, 11))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return 16'sd0;
            3: return -16'sd1;
            4: return 16'sd1;
            5: return 16'sd255;
            6: return -16'sd256;
            7: return 16'sd4660;
            default: return KEY_IO_BITS'($urandom_range(0, 65535));
        endcase
    endfunction

    // A growing chunk is weighted towards appends and inserts to fill the queue; a shrinking one towards removes.
    task automatic push_random_chunk(input bit growing);
        int                  roll;
        logic [CMD_BITS-1:0] cmd;
        logic [POS_BITS-1:0] pos;
        for (int n = 0; n < CHUNK_ITEMS; n++)
        begin
            roll = $urandom_range(0, 99);
            pos = ($urandom_range(0, 9) != 0) ? POS_BITS'($urandom_range(0, 17))
                                              : POS_BITS'($urandom_range(0, 31));
            if (growing)
                cmd = (roll < 55) ? CMD_APPEND :
                      (roll < 75) ? CMD_INSERT :
                      (roll < 83) ? CMD_SEARCH :
                      (roll < 88) ? CMD_COUNT  :
                      (roll < 94) ? CMD_RD_FWD : CMD_RD_REV;
            else
                cmd = (roll < 40) ? CMD_REMOVE :
                      (roll < 55) ? CMD_SEARCH :
                      (roll < 65) ? CMD_RD_FWD :
                      (roll < 75) ? CMD_RD_REV :
                      (roll < 83) ? CMD_INSERT :
                      (roll < 91) ? CMD_APPEND :
                      (roll < 96) ? CMD_COUNT  : CMD_UNUSED;
            push_cmd(cmd, pick_key(), pos);
        end
        if (growing)
        begin
            push_cmd(CMD_INSERT, pick_key(), '0);
            push_cmd(CMD_APPEND, pick_key(), '0);
        end
    endtask

    task automatic wait_until_drained();
        while (pending_cmds.size() != 0 || in_valid || expected_beats.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_cmd(CMD_RD_FWD, 16'sd0, 5'd0);
        push_cmd(CMD_RD_REV, 16'sd0, 5'd0);
        push_cmd(CMD_SEARCH, 16'sd0, 5'd0);
        push_cmd(CMD_REMOVE, 16'sd0, 5'd0);
        push_cmd(CMD_COUNT, 16'sd0, 5'd0);
        push_cmd(CMD_INSERT, 16'sd5, 5'd0);
        push_cmd(CMD_INSERT, 16'sd5, 5'd2);
        push_cmd(CMD_INSERT, 16'sd32767, 5'd1);
        push_cmd(CMD_APPEND, -16'sd32768, 5'd31);
        push_cmd(CMD_INSERT, -16'sd1, 5'd3);
        push_cmd(CMD_INSERT, 16'sd21845, 5'd2);
        push_cmd(CMD_INSERT, -16'sd21846, 5'd31);
        push_cmd(CMD_SEARCH, -16'sd1, 5'd0);
        push_cmd(CMD_SEARCH, 16'sd1234, 5'd0);
        push_cmd(CMD_UNUSED, -16'sd1, 5'd31);
        push_cmd(CMD_RD_FWD, 16'sd0, 5'd0);
        push_cmd(CMD_RD_REV, 16'sd0, 5'd0);
        push_cmd(CMD_REMOVE, -16'sd1, 5'd0);
        push_cmd(CMD_REMOVE, 16'sd99, 5'd0);
        push_cmd(CMD_COUNT, 16'sd0, 5'd0);
        wait_until_drained();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 79; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 79; end
                default: begin send_idle_pct = 29; stall_pct = 29; end
            endcase
            push_random_chunk(1'b1);
            push_random_chunk(1'b0);
            push_random_chunk(1'b1);
            wait_until_drained();
        end

        repeat (END_CYCLES) @(posedge clk);
        if (expected_beats.size() != 0)
            report_mismatch($sformatf("%0d beats never arrived", expected_beats.size()));
        $display("Ran %0d commands and checked %0d result beats, %0d from read-outs.",
                 commands_accepted, beats_checked, readout_beats);
        $display("Saw %0d full refusals and %0d not-found or bad-position results.",
                 full_refusals, miss_refusals);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("timeout: %0d commands still pending, %0d beats expected",
                 pending_cmds.size(), expected_beats.size());
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/pkq_pkg.sv
hdl/pkq_ram.sv
hdl/positional_key_queue_unit.sv
tb/tb_positional_key_queue_unit.sv
